>>> design/spqb_pkg.sv
`timescale 1ns / 1ps

package spqb_pkg;

    // Queue capacity and derived widths
    localparam int DEPTH   = 16;
    localparam int OCC_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 16;
    localparam int LEVEL_W = 16;
    localparam int ARR_W   = 16;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_EXTRACT = 2'd1,
        OP_REMOVE  = 2'd2,
        OP_BOOST   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DROP   = 2'd2
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_REINSERT
    } state_t;

    typedef struct packed {
        op_t                        operation;
        logic [KEY_W-1:0]           player_key;
        logic [LEVEL_W-1:0]         new_level;
        logic signed [LEVEL_W-1:0]  boost_amount;
    } in_item_t;

    typedef struct packed {
        status_t              status;
        logic [KEY_W-1:0]     out_key;
        logic [LEVEL_W-1:0]   out_level;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [LEVEL_W-1:0]   level;
        logic [ARR_W-1:0]     arrival;
    } entry_t;

    // Command broadcast to every cell in the row
    typedef struct packed {
        cell_op_t             mode;
        logic                 by_head;
        logic [KEY_W-1:0]     key;
        entry_t               ins;
    } cell_cmd_t;

endpackage

>>> design/spqb_cell.sv
`timescale 1ns / 1ps

module spqb_cell (
    input  logic                 aclk,
    input  spqb_pkg::cell_cmd_t  cmd,
    input  logic                 valid,
    input  spqb_pkg::entry_t     prev_entry,
    input  spqb_pkg::entry_t     next_entry,
    input  logic                 prev_before,
    input  logic                 found_in,
    input  spqb_pkg::entry_t     sel_in,
    output spqb_pkg::entry_t     entry,
    output logic                 ins_ahead,
    output logic                 found_out,
    output spqb_pkg::entry_t     sel_out
);

    spqb_pkg::entry_t entry_reg;
    spqb_pkg::entry_t entry_next;
    logic             match;

    assign entry = entry_reg;

    // New entry goes ahead of this one (an empty cell always yields)
    assign ins_ahead = !valid
                    || (cmd.ins.level > entry_reg.level)
                    || ((cmd.ins.level == entry_reg.level)
                        && (cmd.ins.arrival < entry_reg.arrival));

    // First matching cell from the head
    assign match     = valid && !found_in && (cmd.by_head || (cmd.key == entry_reg.key));
    assign found_out = found_in || match;
    assign sel_out   = match ? entry_reg : sel_in;

    // Shift toward the tail on insert, toward the head on drop
    always_comb begin
        entry_next = entry_reg;
        unique case (cmd.mode)
            spqb_pkg::CELL_INSERT: begin
                if (prev_before) begin
                    entry_next = prev_entry;
                end else if (ins_ahead) begin
                    entry_next = cmd.ins;
                end
            end
            spqb_pkg::CELL_DROP: begin
                if (found_out) begin
                    entry_next = next_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

>>> design/stable_priority_queue_with_boost_core.sv
`timescale 1ns / 1ps
// The result is registered: valid in the cycle after the transaction is accepted.
// Insert, extract and remove finish on acceptance; a boost finds and drops its entry
// across the cell row, then reinserts it, and takes no new transaction meanwhile.
// A new transaction is taken once the output register is free or being taken.
// Reset (aresetn low, synchronous) empties the queue and clears the arrival count.
module stable_priority_queue_with_boost_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  spqb_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output spqb_pkg::out_item_t  m_data
);

    localparam int D = spqb_pkg::DEPTH;

    spqb_pkg::state_t               state_reg, state_next;
    logic [spqb_pkg::OCC_W-1:0]     occupancy_reg, occupancy_next;
    logic [spqb_pkg::ARR_W-1:0]     arrival_reg, arrival_next;
    spqb_pkg::entry_t               pending_reg, pending_next;
    logic                           m_valid_reg, m_valid_next;
    spqb_pkg::out_item_t            m_data_reg, m_data_next;

    spqb_pkg::cell_cmd_t            cmd;
    spqb_pkg::entry_t               cell_entry [D];
    spqb_pkg::entry_t               cell_sel   [D];
    logic [D-1:0]                   cell_before;
    logic [D-1:0]                   cell_found;
    logic [D-1:0]                   cell_valid;

    logic                           accept;
    logic                           found_any;
    logic                           is_empty;
    logic                           is_full;
    logic signed [spqb_pkg::LEVEL_W+1:0] boost_sum;
    logic [spqb_pkg::LEVEL_W-1:0]   boost_level;

    assign s_ready   = (state_reg == spqb_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign found_any = cell_found[D-1];
    assign is_empty  = (occupancy_reg == '0);
    assign is_full   = (occupancy_reg == spqb_pkg::OCC_W'(D));

    // Build the cell row
    for (genvar i = 0; i < D; i++) begin : g_cell
        spqb_pkg::entry_t prev_e, next_e, sel_i;
        logic             prev_b, found_i;

        assign cell_valid[i] = (spqb_pkg::OCC_W'(i) < occupancy_reg);

        if (i == 0) begin : g_head
            assign prev_e  = '0;
            assign prev_b  = 1'b0;
            assign found_i = 1'b0;
            assign sel_i   = '0;
        end else begin : g_body
            assign prev_e  = cell_entry[i-1];
            assign prev_b  = cell_before[i-1];
            assign found_i = cell_found[i-1];
            assign sel_i   = cell_sel[i-1];
        end

        if (i == D - 1) begin : g_tail
            assign next_e = '0;
        end else begin : g_inner
            assign next_e = cell_entry[i+1];
        end

        spqb_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .valid       (cell_valid[i]),
            .prev_entry  (prev_e),
            .next_entry  (next_e),
            .prev_before (prev_b),
            .found_in    (found_i),
            .sel_in      (sel_i),
            .entry       (cell_entry[i]),
            .ins_ahead   (cell_before[i]),
            .found_out   (cell_found[i]),
            .sel_out     (cell_sel[i])
        );
    end

    // Saturating boost of the selected entry's level
    always_comb begin
        boost_sum = $signed({2'b00, cell_sel[D-1].level})
                  + (spqb_pkg::LEVEL_W+2)'(s_data.boost_amount);
        if (boost_sum < 0) begin
            boost_level = '0;
        end else if (boost_sum > $signed({2'b00, {spqb_pkg::LEVEL_W{1'b1}}})) begin
            boost_level = '1;
        end else begin
            boost_level = boost_sum[spqb_pkg::LEVEL_W-1:0];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            spqb_pkg::ST_IDLE: begin
                if (accept && (s_data.operation == spqb_pkg::OP_BOOST)
                    && !is_empty && found_any) begin
                    state_next = spqb_pkg::ST_REINSERT;
                end
            end
            spqb_pkg::ST_REINSERT: begin
                state_next = spqb_pkg::ST_IDLE;
            end
            default: begin
                state_next = spqb_pkg::ST_IDLE;
            end
        endcase
    end

    // Command broadcast to the cell row
    always_comb begin
        cmd             = '0;
        cmd.mode        = spqb_pkg::CELL_HOLD;
        cmd.key         = s_data.player_key;
        cmd.ins.key     = s_data.player_key;
        cmd.ins.level   = s_data.new_level;
        cmd.ins.arrival = arrival_reg + 1'b1;
        if (state_reg == spqb_pkg::ST_REINSERT) begin
            cmd.mode = spqb_pkg::CELL_INSERT;
            cmd.ins  = pending_reg;
        end else if (accept) begin
            priority if (s_data.operation == spqb_pkg::OP_INSERT) begin
                if (!is_full) begin
                    cmd.mode = spqb_pkg::CELL_INSERT;
                end
            end else if (!is_empty) begin
                cmd.mode    = spqb_pkg::CELL_DROP;
                cmd.by_head = (s_data.operation == spqb_pkg::OP_EXTRACT);
            end
        end
    end

    // Counters and result
    always_comb begin
        occupancy_next = occupancy_reg;
        arrival_next   = arrival_reg;
        pending_next   = pending_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            spqb_pkg::ST_REINSERT: begin
                occupancy_next = occupancy_reg + 1'b1;
            end
            default: begin
                if (accept) begin
                    m_valid_next          = 1'b1;
                    m_data_next           = '0;
                    m_data_next.status    = spqb_pkg::STATUS_OK;
                    priority if (s_data.operation == spqb_pkg::OP_INSERT) begin
                        if (is_full) begin
                            m_data_next.status = spqb_pkg::STATUS_FULL;
                        end else begin
                            arrival_next   = arrival_reg + 1'b1;
                            occupancy_next = occupancy_reg + 1'b1;
                        end
                    end else if (is_empty) begin
                        m_data_next.status = spqb_pkg::STATUS_EMPTY;
                    end else if (s_data.operation == spqb_pkg::OP_EXTRACT) begin
                        occupancy_next        = occupancy_reg - 1'b1;
                        m_data_next.out_key   = cell_entry[0].key;
                        m_data_next.out_level = cell_entry[0].level;
                    end else begin
                        if (found_any) begin
                            occupancy_next        = occupancy_reg - 1'b1;
                            pending_next.key      = cell_sel[D-1].key;
                            pending_next.level    = boost_level;
                            pending_next.arrival  = cell_sel[D-1].arrival;
                        end else begin
                            m_data_next.status = spqb_pkg::STATUS_NOT_FOUND;
                        end
                    end
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= spqb_pkg::ST_IDLE;
            occupancy_reg <= '0;
            arrival_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occupancy_reg <= occupancy_next;
            arrival_reg   <= arrival_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pending_reg <= pending_next;
        m_data_reg  <= m_data_next;
    end

endmodule
